@@ src/tt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tt_pkg
// Shared widths and types of the triangle tangent unit.
// ----------------------------------------------------------------------------
package tt_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int NORM_BITS     = 30;

  localparam int DW    = COORD_WIDTH + 1;          // differences
  localparam int PW    = 2 * DW;                   // products
  localparam int TW    = PW + 1;                   // det and raw tangent
  localparam int LENW  = $clog2(TW + 1);
  localparam int SQW   = 2 * NORM_BITS;            // one square
  localparam int SUMW  = SQW + 2;                  // sum of three squares
  localparam int RW    = NORM_BITS + 1;            // root
  localparam int SQ_STEPS = SUMW / 2;
  localparam int QW    = OUT_FRAC_BITS + 1;        // quotient
  localparam int NUMW  = NORM_BITS + OUT_FRAC_BITS + 1;
  localparam int OUTW  = OUT_FRAC_BITS + 2;

  localparam int IN_TDATA_W  = 9 * COORD_WIDTH + 3 * 2 * COORD_WIDTH;
  localparam int OUT_TDATA_W = 3 * OUTW;

  // Per-item data that rides along the scale, square and root stages
  typedef struct packed {
    logic                          deg;
    logic [2:0]                    neg;
    logic [2:0][NORM_BITS-1:0]     mag;
  } side_t;

endpackage
`default_nettype wire

@@ src/triangle_tangent_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_unit
// Pipelined per-triangle tangent: edge and UV differences, signed tangent,
// normalization by square root and division to a unit vector in Q1.14.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_axis    in   a_x a_y a_z b_x b_y b_z c_x c_y c_z    -
//                 a_uv b_uv c_uv (240 bits)
//  m_axis    out  tangent_x tangent_y tangent_z (48 b)   degenerate
//
//  One triangle per cycle while the output is not held, 57 register stages from input to output register.
//  Depth is set by the 31 root stages and 15 quotient stages.
//  rst clears the valid bits only; payload registers are not reset.
//  The whole pipe holds when the output holds an unaccepted transaction;
//  s_axis_tready follows that hold.
// ----------------------------------------------------------------------------
module triangle_tangent_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, a_uv, b_uv, c_uv
  input  wire logic [tt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tangent_x, tangent_y, tangent_z
  output logic [tt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // degenerate
  output logic                                m_axis_tuser
);

  localparam int CW    = tt_pkg::COORD_WIDTH;
  localparam int DW    = tt_pkg::DW;
  localparam int PW    = tt_pkg::PW;
  localparam int TW    = tt_pkg::TW;
  localparam int LENW  = tt_pkg::LENW;
  localparam int NB    = tt_pkg::NORM_BITS;
  localparam int SQW   = tt_pkg::SQW;
  localparam int SUMW  = tt_pkg::SUMW;
  localparam int RW    = tt_pkg::RW;
  localparam int NSQ   = tt_pkg::SQ_STEPS;
  localparam int QW    = tt_pkg::QW;
  localparam int NUMW  = tt_pkg::NUMW;
  localparam int OFB   = tt_pkg::OUT_FRAC_BITS;
  localparam int OUTW  = tt_pkg::OUTW;
  localparam int FRONT = 9;
  localparam int TOTAL = FRONT + NSQ + 1 + QW + 1;

  logic             adv;
  logic [TOTAL-1:0] vld;

  assign adv           = m_axis_tready || !vld[TOTAL-1];
  assign s_axis_tready = adv && !rst;
  assign m_axis_tvalid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: unpack and difference
  logic signed [CW-1:0] pos [9];
  logic signed [CW-1:0] uu [3];
  logic signed [CW-1:0] vv [3];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pos[i] = s_axis_tdata[i*CW +: CW];
    end
    for (int i = 0; i < 3; i++) begin
      uu[i] = s_axis_tdata[9*CW + i*2*CW +: CW];
      vv[i] = s_axis_tdata[9*CW + i*2*CW + CW +: CW];
    end
  end

  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      du1 <= DW'(uu[1]) - DW'(uu[0]);
      dv1 <= DW'(vv[1]) - DW'(vv[0]);
      du2 <= DW'(uu[2]) - DW'(uu[0]);
      dv2 <= DW'(vv[2]) - DW'(vv[0]);
      for (int i = 0; i < 3; i++) begin
        e1[i] <= DW'(pos[3+i]) - DW'(pos[i]);
        e2[i] <= DW'(pos[6+i]) - DW'(pos[i]);
      end
    end
  end

  // ---- stage 2: products
  logic signed [PW-1:0] pa, pb;
  logic signed [PW-1:0] pt1 [3];
  logic signed [PW-1:0] pt2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= du1 * dv2;
      pb <= du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        pt1[i] <= dv2 * e1[i];
        pt2[i] <= dv1 * e2[i];
      end
    end
  end

  // ---- stage 3: determinant and raw tangent
  logic signed [TW-1:0] det;
  logic signed [TW-1:0] tr [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      det <= TW'(pa) - TW'(pb);
      for (int i = 0; i < 3; i++) begin
        tr[i] <= TW'(pt1[i]) - TW'(pt2[i]);
      end
    end
  end

  // ---- stage 4: magnitudes and signs
  logic [TW-1:0] mag4 [3];
  logic [2:0]    tneg4;
  logic          detneg4, detz4;

  always_ff @(posedge clk) begin
    if (adv) begin
      detz4   <= (det == '0);
      detneg4 <= det[TW-1];
      for (int i = 0; i < 3; i++) begin
        tneg4[i] <= tr[i][TW-1];
        mag4[i]  <= tr[i][TW-1] ? TW'(-tr[i]) : TW'(tr[i]);
      end
    end
  end

  // ---- stage 5: largest magnitude
  logic [TW-1:0] mag5 [3];
  logic [TW-1:0] mx5;
  logic [TW-1:0] mx01;
  logic [2:0]    neg5;
  logic          detz5;

  assign mx01 = (mag4[1] > mag4[0]) ? mag4[1] : mag4[0];

  always_ff @(posedge clk) begin
    if (adv) begin
      mx5   <= (mag4[2] > mx01) ? mag4[2] : mx01;
      mag5  <= mag4;
      neg5  <= tneg4 ^ {3{detneg4}};
      detz5 <= detz4;
    end
  end

  // ---- stage 6: bit length of the largest magnitude
  logic [LENW-1:0] len_c;
  logic [LENW-1:0] len6;
  logic [TW-1:0]   mag6 [3];
  logic [2:0]      neg6;
  logic            deg6;

  always_comb begin
    len_c = '0;
    for (int b = 0; b < TW; b++) begin
      if (mx5[b]) begin
        len_c = LENW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len6 <= len_c;
      mag6 <= mag5;
      neg6 <= neg5;
      deg6 <= detz5 || (mx5 == '0);
    end
  end

  // ---- stage 7: scale to NB significant bits
  tt_pkg::side_t side7;
  logic [TW-1:0] shf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len6 > LENW'(NB)) begin
        shf[i] = mag6[i] >> (len6 - LENW'(NB));
      end else begin
        shf[i] = mag6[i] << (LENW'(NB) - len6);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side7.deg <= deg6;
      side7.neg <= neg6;
      for (int i = 0; i < 3; i++) begin
        side7.mag[i] <= shf[i][NB-1:0];
      end
    end
  end

  // ---- stage 8: squares
  tt_pkg::side_t side8;
  logic [SQW-1:0] sqr8 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      side8 <= side7;
      for (int i = 0; i < 3; i++) begin
        sqr8[i] <= side7.mag[i] * side7.mag[i];
      end
    end
  end

  // ---- stage 9: sum of squares
  logic [SUMW-1:0] sq_n   [NSQ+1];
  logic [SUMW-1:0] sq_res [NSQ+1];
  tt_pkg::side_t   sq_side [NSQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= SUMW'(sqr8[0]) + SUMW'(sqr8[1]) + SUMW'(sqr8[2]);
      sq_res[0]  <= '0;
      sq_side[0] <= side8;
    end
  end

  // ---- root stages: one result bit each
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (2 * (NSQ - 1 - k));
    logic [SUMW:0] trial;

    assign trial = {1'b0, sq_res[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side[k+1] <= sq_side[k];
        if ({1'b0, sq_n[k]} >= trial) begin
          sq_n[k+1]   <= SUMW'({1'b0, sq_n[k]} - trial);
          sq_res[k+1] <= (sq_res[k] >> 1) + BIT;
        end else begin
          sq_n[k+1]   <= sq_n[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  // ---- divide setup: rounded numerator
  logic [RW-1:0] root;
  logic [NUMW-1:0] dv_rem [QW+1][3];
  logic [QW-1:0]   dv_q   [QW+1][3];
  logic [RW-1:0]   dv_r   [QW+1];
  logic [2:0]      dv_neg [QW+1];
  logic            dv_deg [QW+1];

  assign root = sq_res[NSQ][RW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]   <= root;
      dv_neg[0] <= sq_side[NSQ].neg;
      dv_deg[0] <= sq_side[NSQ].deg;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {sq_side[NSQ].mag[i], OFB'(0)} + NUMW'(root >> 1);
        dv_q[0][i]   <= '0;
      end
    end
  end

  // ---- quotient stages: one bit each, three lanes
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    logic [NUMW-1:0] dvs;

    assign dvs = NUMW'(dv_r[k]) << J;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1]   <= dv_r[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_deg[k+1] <= dv_deg[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[k][i] >= dvs) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - dvs;
            dv_q[k+1][i]   <= dv_q[k][i] | (QW'(1) << J);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
      end
    end
  end

  // ---- output register: clamp, sign, degenerate
  localparam logic [QW-1:0] QONE = QW'(1) << OFB;
  logic [QW-1:0]   qc [3];
  logic [OUTW-1:0] ov [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[QW][i] > QONE) ? QONE : dv_q[QW][i];
      ov[i] = dv_neg[QW][i] ? OUTW'(-{1'b0, qc[i]}) : OUTW'({1'b0, qc[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= dv_deg[QW];
      for (int i = 0; i < 3; i++) begin
        m_axis_tdata[i*OUTW +: OUTW] <= dv_deg[QW] ? '0 : ov[i];
      end
    end
  end

`ifndef ASSERT_OFF
  logic signed [OUTW-1:0] ox, oy, oz;
  assign ox = m_axis_tdata[0 +: OUTW];
  assign oy = m_axis_tdata[OUTW +: OUTW];
  assign oz = m_axis_tdata[2*OUTW +: OUTW];

  // degenerate results carry a zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero tangent");

  // a unit vector never has all components zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
    else $error("valid tangent is the zero vector");

  // components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ox <= $signed(OUTW'(QONE)) && ox >= -$signed(OUTW'(QONE))
      && oy <= $signed(OUTW'(QONE)) && oy >= -$signed(OUTW'(QONE))
      && oz <= $signed(OUTW'(QONE)) && oz >= -$signed(OUTW'(QONE)))
    else $error("tangent component out of range");
`endif

endmodule
`default_nettype wire
